[design/ssfs_pkg.sv]
`timescale 1ns / 1ps
package ssfs_pkg;

  localparam int unsigned PcW = 4;

  localparam logic [2:0] RegMinPos    = 3'd0;
  localparam logic [2:0] RegMaxPos    = 3'd1;
  localparam logic [2:0] RegFriction  = 3'd2;
  localparam logic [2:0] RegStiffness = 3'd3;
  localparam logic [2:0] RegDamping   = 3'd4;
  localparam logic [2:0] RegVelTol    = 3'd5;
  localparam logic [2:0] RegPosTol    = 3'd6;
  localparam logic [2:0] RegScale     = 3'd7;

  localparam logic [PcW-1:0] EntryTick   = 4'd0;
  localparam logic [PcW-1:0] EntryFric   = 4'd4;
  localparam logic [PcW-1:0] EntryCommon = 4'd6;
  localparam logic [PcW-1:0] EntryRest   = 4'd11;
  localparam logic [PcW-1:0] EntryLoad   = 4'd15;

  typedef struct packed {
    logic signed [31:0] min_pos;
    logic signed [31:0] max_pos;
    logic signed [31:0] friction;
    logic signed [31:0] stiffness;
    logic signed [31:0] damping;
    logic [30:0]        vel_tol;
    logic signed [31:0] pos_tol;
    logic signed [31:0] scale;
  } cfg_t;

  typedef enum logic [3:0] {
    A_DIST, A_DAMP, A_FRIC, A_VEL, A_HALF, A_ACC, A_TMP, A_POS, A_MAX, A_MIN
  } a_sel_e;

  typedef enum logic [1:0] {
    B_STIFF, B_VEL, B_DT, B_SCALE
  } b_sel_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_PREP, OP_SPW, OP_ACCS, OP_ACCF, OP_T1, OP_TMP, OP_DV, OP_UPD,
    OP_DIST, OP_PW, OP_HI, OP_FIN, OP_LOAD
  } op_e;

  typedef enum logic [1:0] {
    J_NEXT, J_ALWAYS, J_DIST0, J_END
  } jmp_e;

  typedef enum logic {
    ST_IDLE, ST_RUN
  } state_e;

  typedef struct packed {
    a_sel_e         a;
    b_sel_e         b;
    op_e            op;
    jmp_e           jmp;
    logic [PcW-1:0] tgt;
  } ctrl_t;

  function automatic ctrl_t mk(input a_sel_e a, input b_sel_e b, input op_e op,
                               input jmp_e jmp, input logic [PcW-1:0] tgt);
    ctrl_t c;
    c.a   = a;
    c.b   = b;
    c.op  = op;
    c.jmp = jmp;
    c.tgt = tgt;
    return c;
  endfunction

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    unique case (pc)
      4'd0:  c = mk(A_DIST, B_STIFF, OP_PREP, J_NEXT,   EntryTick);
      4'd1:  c = mk(A_DIST, B_STIFF, OP_NOP,  J_DIST0,  EntryFric);
      4'd2:  c = mk(A_DAMP, B_VEL,   OP_SPW,  J_NEXT,   EntryTick);
      4'd3:  c = mk(A_DAMP, B_VEL,   OP_ACCS, J_ALWAYS, EntryCommon);
      4'd4:  c = mk(A_FRIC, B_VEL,   OP_NOP,  J_NEXT,   EntryTick);
      4'd5:  c = mk(A_FRIC, B_VEL,   OP_ACCF, J_NEXT,   EntryTick);
      4'd6:  c = mk(A_VEL,  B_DT,    OP_NOP,  J_NEXT,   EntryTick);
      4'd7:  c = mk(A_HALF, B_DT,    OP_T1,   J_NEXT,   EntryTick);
      4'd8:  c = mk(A_ACC,  B_DT,    OP_TMP,  J_NEXT,   EntryTick);
      4'd9:  c = mk(A_TMP,  B_DT,    OP_DV,   J_NEXT,   EntryTick);
      4'd10: c = mk(A_TMP,  B_DT,    OP_UPD,  J_NEXT,   EntryTick);
      4'd11: c = mk(A_POS,  B_SCALE, OP_DIST, J_NEXT,   EntryTick);
      4'd12: c = mk(A_MAX,  B_SCALE, OP_PW,   J_NEXT,   EntryTick);
      4'd13: c = mk(A_MIN,  B_SCALE, OP_HI,   J_NEXT,   EntryTick);
      4'd14: c = mk(A_MIN,  B_SCALE, OP_FIN,  J_END,    EntryTick);
      4'd15: c = mk(A_POS,  B_SCALE, OP_LOAD, J_ALWAYS, EntryRest);
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] limit_dist(input logic signed [31:0] pos,
                                                    input logic signed [31:0] max_pos,
                                                    input logic signed [31:0] min_pos);
    logic signed [31:0] r;
    priority if (pos > max_pos) begin
      r = sat32({{34{max_pos[31]}}, max_pos} - {{34{pos[31]}}, pos});
    end else if (pos < min_pos) begin
      r = sat32({{34{min_pos[31]}}, min_pos} - {{34{pos[31]}}, pos});
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

[design/ssfs_cfg.sv]
`timescale 1ns / 1ps
module ssfs_cfg
  import ssfs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  localparam logic signed [31:0] ScaleOne = 32'(64'd1 << FRAC_BITS);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pos   <= 32'sh8000_0000;
      cfg_q.max_pos   <= 32'sh7FFF_FFFF;
      cfg_q.friction  <= '0;
      cfg_q.stiffness <= '0;
      cfg_q.damping   <= '0;
      cfg_q.vel_tol   <= '0;
      cfg_q.pos_tol   <= '0;
      cfg_q.scale     <= ScaleOne;
    end else if (wr) begin
      unique case (idx)
        RegMinPos:    cfg_q.min_pos   <= pwdata;
        RegMaxPos:    cfg_q.max_pos   <= pwdata;
        RegFriction:  cfg_q.friction  <= pwdata;
        RegStiffness: cfg_q.stiffness <= pwdata;
        RegDamping:   cfg_q.damping   <= pwdata;
        RegVelTol:    cfg_q.vel_tol   <= pwdata[30:0];
        RegPosTol:    cfg_q.pos_tol   <= pwdata;
        RegScale:     cfg_q.scale     <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMinPos:    prdata = cfg_q.min_pos;
      RegMaxPos:    prdata = cfg_q.max_pos;
      RegFriction:  prdata = cfg_q.friction;
      RegStiffness: prdata = cfg_q.stiffness;
      RegDamping:   prdata = cfg_q.damping;
      RegVelTol:    prdata = {1'b0, cfg_q.vel_tol};
      RegPosTol:    prdata = cfg_q.pos_tol;
      RegScale:     prdata = cfg_q.scale;
    endcase
  end

endmodule

[design/scroll_spring_friction_step.sv]
`timescale 1ns / 1ps
// Scroll dynamics step: holds position, velocity and last time (signed fixed point with
// FRAC_BITS fraction bits) and returns one word per input word. A tick passes from
// acceptance to a registered result through 13 microcode steps (spring and friction
// branches alike) that share a single 32x32 multiplier with a
// registered product. A set-state word passes through acceptance, load, then the 4-step
// limit and rest evaluation. A new input word is taken as soon as the sequencer is idle,
// while the previous result may still wait on the output register; the final step holds
// until that register is free.
module scroll_spring_friction_step
  import ssfs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_time, load_position, load_velocity
  input  logic [95:0]  s_axis_tdata,
  // opcode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cur_position, cur_velocity, limit_distance, at_rest, zero pad
  output logic [103:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic signed [31:0] MaxDt = 32'(((64'd1 << FRAC_BITS) + 64'd30) / 64'd60);

  cfg_t cfg;

  ssfs_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  ctrl_t          ctrl;
  logic           in_acc, adv, fin;
  logic           out_valid_q, out_valid_d;

  logic signed [31:0] now_q, ld_pos_q, ld_vel_q;
  logic signed [31:0] pos_q, vel_q, last_q;
  logic signed [31:0] dt_q, dist_q, sp_q, acc_q, t1_q, tmp_q, dv_q;
  logic signed [63:0] prod_q, p_q, hi_q;
  logic signed [31:0] op_a, op_b, half, sh_sat, dt_raw;
  logic signed [63:0] sh;

  logic signed [31:0] out_pos_q, out_vel_q, out_dist_q, odist_q;
  logic               out_rest_q, rest;
  logic [32:0]        vel_abs;
  logic signed [65:0] p_ext, tol_ext;

  assign ctrl   = ucode(pc_q);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign fin    = (ctrl.op == OP_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= EntryTick;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    adv           = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_RUN;
          pc_d    = s_axis_tuser[0] ? EntryLoad : EntryTick;
        end
      end
      ST_RUN: begin
        adv = !(fin && out_valid_q && !m_axis_tready);
        if (adv) begin
          unique case (ctrl.jmp)
            J_NEXT:   pc_d = pc_q + 4'd1;
            J_ALWAYS: pc_d = ctrl.tgt;
            J_DIST0:  pc_d = (dist_q == '0) ? ctrl.tgt : pc_q + 4'd1;
            J_END: begin
              state_d     = ST_IDLE;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  assign half = acc_q >>> 1;

  always_comb begin
    unique case (ctrl.a)
      A_DIST:  op_a = dist_q;
      A_DAMP:  op_a = cfg.damping;
      A_FRIC:  op_a = cfg.friction;
      A_VEL:   op_a = vel_q;
      A_HALF:  op_a = half;
      A_ACC:   op_a = acc_q;
      A_TMP:   op_a = tmp_q;
      A_POS:   op_a = pos_q;
      A_MAX:   op_a = cfg.max_pos;
      A_MIN:   op_a = cfg.min_pos;
      default: op_a = '0;
    endcase
    unique case (ctrl.b)
      B_STIFF: op_b = cfg.stiffness;
      B_VEL:   op_b = vel_q;
      B_DT:    op_b = dt_q;
      B_SCALE: op_b = cfg.scale;
    endcase
  end

  assign sh     = prod_q >>> FRAC_BITS;
  assign sh_sat = sat32({{2{sh[63]}}, sh});
  assign dt_raw = sat32({{34{now_q[31]}}, now_q} - {{34{last_q[31]}}, last_q});

  // rest test with the min-limit product taken straight from the multiplier
  assign vel_abs = vel_q[31] ? (33'd0 - {1'b1, vel_q}) : {1'b0, vel_q};
  assign p_ext   = {{2{p_q[63]}}, p_q};
  assign tol_ext = {{34{cfg.pos_tol[31]}}, cfg.pos_tol};
  assign rest    = (vel_abs < {2'b00, cfg.vel_tol})
                && (p_ext - tol_ext < $signed({{2{hi_q[63]}}, hi_q}))
                && (p_ext + tol_ext > $signed({{2{sh[63]}}, sh}));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= s_axis_tdata[31:0];
      ld_pos_q <= s_axis_tdata[63:32];
      ld_vel_q <= s_axis_tdata[95:64];
    end
    if (adv) begin
      prod_q <= op_a * op_b;
      unique case (ctrl.op)
        OP_PREP: begin
          dt_q   <= (dt_raw > MaxDt) ? MaxDt : dt_raw;
          dist_q <= limit_dist(pos_q, cfg.max_pos, cfg.min_pos);
        end
        OP_SPW:  sp_q <= sh_sat;
        OP_ACCS: acc_q <= sat32({{34{sp_q[31]}}, sp_q} - {{34{sh_sat[31]}}, sh_sat});
        OP_ACCF: acc_q <= sat32(66'sd0 - {{34{sh_sat[31]}}, sh_sat});
        OP_T1:   t1_q <= sh_sat;
        OP_TMP:  tmp_q <= sh_sat;
        OP_DV:   dv_q <= sh_sat;
        OP_DIST: odist_q <= limit_dist(pos_q, cfg.max_pos, cfg.min_pos);
        OP_PW:   p_q <= sh;
        OP_HI:   hi_q <= sh;
        OP_FIN: begin
          out_pos_q  <= pos_q;
          out_vel_q  <= vel_q;
          out_dist_q <= odist_q;
          out_rest_q <= rest;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vel_q  <= '0;
      last_q <= '0;
    end else if (adv) begin
      unique case (ctrl.op)
        OP_PREP: last_q <= now_q;
        OP_UPD: begin
          pos_q <= sat32({{34{pos_q[31]}}, pos_q} + {{34{t1_q[31]}}, t1_q}
                         + {{34{sh_sat[31]}}, sh_sat});
          vel_q <= sat32({{34{vel_q[31]}}, vel_q} + {{34{dv_q[31]}}, dv_q});
        end
        OP_LOAD: begin
          pos_q  <= ld_pos_q;
          vel_q  <= ld_vel_q;
          last_q <= now_q;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_rest_q, out_dist_q, out_vel_q, out_pos_q};

endmodule

[design/ssfs_checker.sv]
`timescale 1ns / 1ps
module ssfs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [95:0]  s_axis_tdata,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         pready
);

  logic        in_acc, out_acc;
  logic [1:0]  cnt_q;
  logic        last_ld_q;
  logic [31:0] last_pos_q, last_vel_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      last_ld_q  <= 1'b0;
      last_pos_q <= '0;
      last_vel_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (in_acc) begin
        last_ld_q  <= s_axis_tuser[0];
        last_pos_q <= s_axis_tdata[63:32];
        last_vel_q <= s_axis_tdata[95:64];
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 2'd0)
    else $error("result word without a pending input word");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !s_axis_tready)
    else $error("input taken with two words pending");

  a_load_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && cnt_q == 2'd1 && last_ld_q |->
      m_axis_tdata[31:0] == last_pos_q && m_axis_tdata[63:32] == last_vel_q)
    else $error("set-state result does not echo loaded state");

endmodule

bind scroll_spring_friction_step ssfs_checker u_ssfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .pready       (pready)
);
